[design/pcmr_pkg.sv]
package pcmr_pkg;

    // Defaults of the top-level parameters
    localparam int HISTORY_DEPTH  = 20;
    localparam int GAIN_FRAC_BITS = 24;
    localparam int SAMPLE_BITS    = 24;

    // Fixed field widths
    localparam int OP_W    = 2;
    localparam int PARAM_W = 32;
    localparam int STEP_W  = 25;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [STEP_W-1:0] STEP_RESET = 25'd34953;

    // Words buffered between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_PARAM  = 2'd1,
        OP_FILTER = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FADE_IN  = 2'd0,
        CFG_FADE_OUT = 2'd1,
        CFG_INIT     = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

[design/pcmr_front.sv]
module pcmr_front #(
    parameter int HISTORY_DEPTH  = pcmr_pkg::HISTORY_DEPTH,
    parameter int GAIN_FRAC_BITS = pcmr_pkg::GAIN_FRAC_BITS,
    parameter int SAMPLE_BITS    = pcmr_pkg::SAMPLE_BITS,
    parameter int WORD_W         = SAMPLE_BITS + GAIN_FRAC_BITS + 1 + pcmr_pkg::PARAM_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [pcmr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pcmr_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [pcmr_pkg::OP_W-1:0]     i_op,
    input  logic [SAMPLE_BITS-1:0]        i_sample,
    input  logic [pcmr_pkg::PARAM_W-1:0]  i_param,
    input  pcmr_pkg::t_q_flags            i_q,
    output logic                          o_push,
    output logic [WORD_W-1:0]             o_word
);

    localparam int GW   = GAIN_FRAC_BITS + 1;
    localparam int EW   = ((GW > pcmr_pkg::STEP_W) ? GW : pcmr_pkg::STEP_W) + 1;
    localparam int PTRW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [GW-1:0]   GAIN_ONE = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
    localparam logic [PTRW-1:0] PTR_LAST = PTRW'(HISTORY_DEPTH - 1);

    logic [pcmr_pkg::STEP_W-1:0]  r_in_step;
    logic [pcmr_pkg::STEP_W-1:0]  r_out_step;
    logic [pcmr_pkg::PARAM_W-1:0] r_hist [HISTORY_DEPTH];
    logic [PTRW-1:0]              r_wptr;
    logic                         r_changed;
    logic [GW-1:0]                r_gain;
    logic [pcmr_pkg::PARAM_W-1:0] r_held;

    logic [GW-1:0]                n_gain;
    logic [pcmr_pkg::PARAM_W-1:0] n_held;
    logic                         w_unsettled;
    logic                         w_accept;
    logic [EW-1:0]                w_up;
    logic [EW-1:0]                w_down;
    logic [SAMPLE_BITS-1:0]       w_sample;

    assign o_ready  = !i_q.full;
    assign w_accept = i_valid && !i_q.full;

    // Any neighboring pair that differs marks the history unsettled
    always_comb begin
        w_unsettled = 1'b0;
        for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
            if (r_hist[i] != r_hist[i+1]) begin
                w_unsettled = 1'b1;
            end
        end
    end

    always_comb begin
        w_up   = EW'(r_gain) + EW'(r_in_step);
        w_down = EW'(r_gain) - EW'(r_out_step);
        if (!r_changed) begin
            n_gain = (w_up > EW'(GAIN_ONE)) ? GAIN_ONE : w_up[GW-1:0];
        end else begin
            n_gain = (EW'(r_gain) > EW'(r_out_step)) ? w_down[GW-1:0] : '0;
        end
    end

    always_comb begin
        n_held   = r_held;
        w_sample = '0;
        case (i_op)
            pcmr_pkg::OP_SAMPLE: w_sample = i_sample;
            pcmr_pkg::OP_FILTER: begin
                if (!w_unsettled) begin
                    n_held = i_param;
                end
            end
            default: ;
        endcase
    end

    // Non-sample words carry a zero sample, so the back end answers zero
    assign o_push = w_accept;
    assign o_word = {n_held, n_gain, w_sample};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_step  <= pcmr_pkg::STEP_RESET;
            r_out_step <= pcmr_pkg::STEP_RESET;
            r_wptr     <= '0;
            r_changed  <= 1'b0;
            r_gain     <= GAIN_ONE;
            r_held     <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                pcmr_pkg::CFG_FADE_IN:  r_in_step  <= i_cfg_wdata[pcmr_pkg::STEP_W-1:0];
                pcmr_pkg::CFG_FADE_OUT: r_out_step <= i_cfg_wdata[pcmr_pkg::STEP_W-1:0];
                pcmr_pkg::CFG_INIT: begin
                    r_held <= i_cfg_wdata;
                    for (int i = 0; i < HISTORY_DEPTH; i++) begin
                        r_hist[i] <= i_cfg_wdata;
                    end
                end
                default: ;
            endcase
        end else if (w_accept) begin
            r_held <= n_held;
            case (i_op)
                pcmr_pkg::OP_SAMPLE: r_gain <= n_gain;
                pcmr_pkg::OP_PARAM: begin
                    r_changed      <= w_unsettled;
                    r_hist[r_wptr] <= i_param;
                    r_wptr         <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain <= GAIN_ONE)
        else $error("gain above unity");
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wptr <= PTR_LAST)
        else $error("history pointer out of range");
`endif

endmodule

[design/pcmr_queue.sv]
module pcmr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pcmr_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_word,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_word,
    output pcmr_pkg::t_q_flags o_q
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;

    assign o_word  = r_mem[r_rd];
    assign o_q.full  = (r_count == CW'(DEPTH));
    assign o_q.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_q.empty)
        else $error("pop from empty queue");
`endif

endmodule

[design/pcmr_back.sv]
module pcmr_back #(
    parameter int GAIN_FRAC_BITS = pcmr_pkg::GAIN_FRAC_BITS,
    parameter int SAMPLE_BITS    = pcmr_pkg::SAMPLE_BITS,
    parameter int WORD_W         = SAMPLE_BITS + GAIN_FRAC_BITS + 1 + pcmr_pkg::PARAM_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pcmr_pkg::t_q_flags           i_q,
    input  logic [WORD_W-1:0]            i_word,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [SAMPLE_BITS-1:0]       o_sample,
    output logic [pcmr_pkg::PARAM_W-1:0] o_param
);

    localparam int GW = GAIN_FRAC_BITS + 1;
    localparam int PW = SAMPLE_BITS + GW + 1;
    localparam int QW = SAMPLE_BITS + 2;
    localparam logic signed [PW-1:0] HALF = PW'(1) << (GAIN_FRAC_BITS - 1);
    localparam logic signed [QW-1:0] QMAX = {3'b000, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [QW-1:0] QMIN = {3'b111, {(SAMPLE_BITS-1){1'b0}}};

    logic                         r_a_valid;
    logic signed [PW-1:0]         r_a_prod;
    logic [pcmr_pkg::PARAM_W-1:0] r_a_param;
    logic                         r_o_valid;
    logic [SAMPLE_BITS-1:0]       r_o_sample;
    logic [pcmr_pkg::PARAM_W-1:0] r_o_param;

    logic                 w_out_take;
    logic                 w_a_take;
    logic signed [PW-1:0] w_s_ext;
    logic signed [PW-1:0] w_g_ext;
    logic signed [PW-1:0] n_prod;
    logic signed [PW-1:0] w_sum;
    logic signed [QW-1:0] w_q;
    logic [SAMPLE_BITS-1:0] n_sample;

    assign w_out_take = !r_o_valid || i_ready;
    assign w_a_take   = !r_a_valid || w_out_take;
    assign o_pop      = !i_q.empty && w_a_take;

    assign w_s_ext = $signed({{(PW-SAMPLE_BITS){i_word[SAMPLE_BITS-1]}},
                              i_word[SAMPLE_BITS-1:0]});
    assign w_g_ext = $signed({{(PW-GW){1'b0}}, i_word[SAMPLE_BITS+GW-1:SAMPLE_BITS]});
    assign n_prod  = w_s_ext * w_g_ext;

    // Round half up, then floor shift and saturate
    always_comb begin
        w_sum = r_a_prod + HALF;
        w_q   = $signed(w_sum[PW-1:GAIN_FRAC_BITS]);
        if (w_q > QMAX) begin
            n_sample = QMAX[SAMPLE_BITS-1:0];
        end else if (w_q < QMIN) begin
            n_sample = QMIN[SAMPLE_BITS-1:0];
        end else begin
            n_sample = w_q[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_take) begin
            r_a_prod  <= n_prod;
            r_a_param <= i_word[WORD_W-1:SAMPLE_BITS+GW];
        end
        if (w_out_take) begin
            r_o_sample <= n_sample;
            r_o_param  <= r_a_param;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_a_take) begin
                r_a_valid <= o_pop;
            end
            if (w_out_take) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    assign o_valid  = r_o_valid;
    assign o_sample = r_o_sample;
    assign o_param  = r_o_param;

`ifndef SYNTHESIS
    a_pop_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_a_valid)
        else $error("popped word lost in multiply stage");
`endif

endmodule

[design/parameter_change_mute_ramp.sv]
// Parameter change mute ramp.
// Input stream: one word per handshake; tuser carries the op (0 sample,
// 1 parameter update, 2 filter query), tdata carries sample_in then
// param_value. Output stream: one word per input word, tdata carries
// sample_out then param_out.
// Config port: write i_cfg_wdata into register i_cfg_idx (0 fade-in step,
// 1 fade-out step, 2 initial parameter) on any edge with i_cfg_wr_en high.
// On accept the front end updates history and change flag (parameter update),
// held word (settled filter query) or gain (sample), and pushes a word into a
// 4-deep queue; the back end multiplies, then rounds and saturates, over two
// register stages. Throughput: one word per cycle while the receiver accepts.
// Words pass the queue, multiply and output registers to o_m_axis_tvalid.
// When the receiver stalls, the output word holds, the pipeline and queue
// fill, and o_s_axis_tready drops once the queue is full.
// Reset clears history and held word to zero, gain to unity, steps to their
// defaults and drops every word in flight.
module parameter_change_mute_ramp #(
    parameter int HISTORY_DEPTH  = pcmr_pkg::HISTORY_DEPTH,
    parameter int GAIN_FRAC_BITS = pcmr_pkg::GAIN_FRAC_BITS,
    parameter int SAMPLE_BITS    = pcmr_pkg::SAMPLE_BITS,
    parameter int DATA_W = ((SAMPLE_BITS + pcmr_pkg::PARAM_W + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [pcmr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pcmr_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [DATA_W-1:0]              i_s_axis_tdata,  // sample_in, param_value
    input  logic [pcmr_pkg::OP_W-1:0]      i_s_axis_tuser,  // op
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [DATA_W-1:0]              o_m_axis_tdata   // sample_out, param_out
);

    localparam int WORD_W = SAMPLE_BITS + GAIN_FRAC_BITS + 1 + pcmr_pkg::PARAM_W;
    localparam int PAD_W  = DATA_W - SAMPLE_BITS - pcmr_pkg::PARAM_W;

    pcmr_pkg::t_q_flags           w_q;
    logic                         w_push;
    logic                         w_pop;
    logic [WORD_W-1:0]            w_in_word;
    logic [WORD_W-1:0]            w_out_word;
    logic [SAMPLE_BITS-1:0]       w_sample;
    logic [pcmr_pkg::PARAM_W-1:0] w_param;

    pcmr_front #(
        .HISTORY_DEPTH  (HISTORY_DEPTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .WORD_W         (WORD_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_op        (i_s_axis_tuser),
        .i_sample    (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_param     (i_s_axis_tdata[SAMPLE_BITS+pcmr_pkg::PARAM_W-1:SAMPLE_BITS]),
        .i_q         (w_q),
        .o_push      (w_push),
        .o_word      (w_in_word)
    );

    pcmr_queue #(
        .WIDTH (WORD_W),
        .DEPTH (pcmr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_word  (w_in_word),
        .i_pop   (w_pop),
        .o_word  (w_out_word),
        .o_q     (w_q)
    );

    pcmr_back #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .WORD_W         (WORD_W)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q      (w_q),
        .i_word   (w_out_word),
        .o_pop    (w_pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_sample (w_sample),
        .o_param  (w_param)
    );

    generate
        if (PAD_W > 0) begin : g_pad
            assign o_m_axis_tdata = {{PAD_W{1'b0}}, w_param, w_sample};
        end else begin : g_nopad
            assign o_m_axis_tdata = {w_param, w_sample};
        end
    endgenerate

endmodule
